### rtl/tvsg_pkg.sv
// shared types, codes and tables for the three voice sound generator
package tvsg_pkg;

  localparam int unsigned NUM_REGS   = 16;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned NUM_VOICES = 3;
  localparam int unsigned TONE_W     = 12;
  localparam int unsigned NOISE_P_W  = 5;
  localparam int unsigned NOISE_C_W  = 6;
  localparam int unsigned NOISE_S_W  = 17;
  localparam int unsigned ENV_P_W    = 16;
  localparam int unsigned ENV_C_W    = 21;
  localparam int unsigned ENV_S_W    = 5;
  localparam int unsigned VOL_W      = 4;
  localparam int unsigned LEVEL_W    = 6;
  localparam int unsigned AMP_W      = 7;

  // operation codes
  localparam logic [1:0] OP_LATCH = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_TONE_A_LO = 4'd0;
  localparam logic [IDX_W-1:0] REG_NOISE_P   = 4'd6;
  localparam logic [IDX_W-1:0] REG_MIXER     = 4'd7;
  localparam logic [IDX_W-1:0] REG_VOL_A     = 4'd8;
  localparam logic [IDX_W-1:0] REG_ENV_LO    = 4'd11;
  localparam logic [IDX_W-1:0] REG_ENV_HI    = 4'd12;
  localparam logic [IDX_W-1:0] REG_ENV_SHAPE = 4'd13;

  // shape register bits
  localparam int unsigned SHAPE_HOLD   = 0;
  localparam int unsigned SHAPE_ALT    = 1;
  localparam int unsigned SHAPE_ATTACK = 2;
  localparam int unsigned SHAPE_CONT   = 3;

  // volume register bit that selects the envelope
  localparam int unsigned VOL_ENV_SEL = 4;

  typedef struct packed {
    logic tick;
    logic restart;
    logic attack;
  } env_ctl_t;

  typedef struct packed {
    logic [2*NUM_VOICES-1:0]        mix_off;
    logic [NUM_VOICES-1:0][4:0]     vol_reg;
    logic [NUM_VOICES-1:0]          tone_level;
    logic                           noise_level;
    logic [VOL_W-1:0]               env_volume;
  } mix_in_t;

  function automatic logic [LEVEL_W-1:0] level_lookup(input logic [VOL_W-1:0] v);
    logic [LEVEL_W-1:0] r;
    case (v)
      4'd0:    r = 6'd0;
      4'd1:    r = 6'd1;
      4'd2:    r = 6'd2;
      4'd3:    r = 6'd3;
      4'd4:    r = 6'd4;
      4'd5:    r = 6'd5;
      4'd6:    r = 6'd7;
      4'd7:    r = 6'd10;
      4'd8:    r = 6'd13;
      4'd9:    r = 6'd18;
      4'd10:   r = 6'd24;
      4'd11:   r = 6'd30;
      4'd12:   r = 6'd36;
      4'd13:   r = 6'd40;
      4'd14:   r = 6'd42;
      default: r = 6'd42;
    endcase
    return r;
  endfunction

endpackage

### rtl/three_voice_sound_generator.sv
// three voice sound generator top level
// an input transaction reaches the result through the input register and then the result register
// throughput: one transaction per cycle while out_stall is low, every operation including ticks
// the input register lets one more transaction in while a result is stalled
// reset: synchronous active-low; register file, counters and handshake state clear,
// noise shift register loads one, all periods read as one
module three_voice_sound_generator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic [6:0] out_amplitude
);

  // input register stage
  logic       s1_valid_r;
  logic [1:0] s1_op_r;
  logic [7:0] s1_data_r;

  // result register stage
  logic       out_valid_r;
  logic [7:0] out_read_data_r, out_read_data_nxt;
  logic [6:0] out_amplitude_r, out_amplitude_nxt;

  // programmer-visible state
  logic [7:0]                 rf_r   [tvsg_pkg::NUM_REGS];
  logic [7:0]                 rf_nxt [tvsg_pkg::NUM_REGS];
  logic [tvsg_pkg::IDX_W-1:0] idx_r;

  logic advance, in_take;
  logic is_latch, is_write, is_read, is_tick;

  logic [tvsg_pkg::NUM_VOICES-1:0][tvsg_pkg::TONE_W-1:0] tone_period;
  logic [tvsg_pkg::NUM_VOICES-1:0]                       tone_level_nxt;
  logic [tvsg_pkg::NOISE_P_W-1:0]                        noise_period;
  logic                                                  noise_level_nxt;
  logic [tvsg_pkg::ENV_P_W-1:0]                          env_period;
  logic [tvsg_pkg::VOL_W-1:0]                            env_volume_nxt;
  tvsg_pkg::env_ctl_t                                    env_ctl;
  tvsg_pkg::mix_in_t                                     mix_in;

  // a held transaction moves on when the result register is empty or draining
  assign advance  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  assign is_latch = advance & (s1_op_r == tvsg_pkg::OP_LATCH);
  assign is_write = advance & (s1_op_r == tvsg_pkg::OP_WRITE);
  assign is_read  = advance & (s1_op_r == tvsg_pkg::OP_READ);
  assign is_tick  = advance & (s1_op_r == tvsg_pkg::OP_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_operation;
      s1_data_r <= in_write_data;
    end
  end

  // register file: the write lands in the next-state view so the mixer sees it
  always_comb begin
    for (int i = 0; i < tvsg_pkg::NUM_REGS; i++) begin
      rf_nxt[i] = (is_write && idx_r == i[tvsg_pkg::IDX_W-1:0]) ? s1_data_r : rf_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tvsg_pkg::NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
      idx_r <= '0;
    end else begin
      for (int i = 0; i < tvsg_pkg::NUM_REGS; i++) begin
        rf_r[i] <= rf_nxt[i];
      end
      if (is_latch) begin
        idx_r <= s1_data_r[tvsg_pkg::IDX_W-1:0];
      end
    end
  end

  // periods come straight from the register bytes, zero counts as one
  always_comb begin
    for (int c = 0; c < tvsg_pkg::NUM_VOICES; c++) begin
      tone_period[c] = {rf_r[2*c + 1][3:0], rf_r[2*c]};
      if (tone_period[c] == '0) begin
        tone_period[c] = 12'd1;
      end
    end
    noise_period = rf_r[tvsg_pkg::REG_NOISE_P][tvsg_pkg::NOISE_P_W-1:0];
    if (noise_period == '0) begin
      noise_period = 5'd1;
    end
    env_period = {rf_r[tvsg_pkg::REG_ENV_HI], rf_r[tvsg_pkg::REG_ENV_LO]};
    if (env_period == '0) begin
      env_period = 16'd1;
    end
  end

  // writing the shape register restarts the envelope
  assign env_ctl.tick    = is_tick;
  assign env_ctl.restart = is_write & (idx_r == tvsg_pkg::REG_ENV_SHAPE);
  assign env_ctl.attack  = s1_data_r[tvsg_pkg::SHAPE_ATTACK];

  genvar g;
  generate
    for (g = 0; g < tvsg_pkg::NUM_VOICES; g++) begin : g_tone
      tvsg_tone u_tone (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (is_tick),
        .period    (tone_period[g]),
        .level_nxt (tone_level_nxt[g])
      );
    end
  endgenerate

  tvsg_noise u_noise (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (is_tick),
    .period    (noise_period),
    .level_nxt (noise_level_nxt)
  );

  tvsg_env u_env (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (env_ctl),
    .period     (env_period),
    .shape      (rf_r[tvsg_pkg::REG_ENV_SHAPE][3:0]),
    .volume_nxt (env_volume_nxt)
  );

  // amplitude reflects the state after this transaction
  always_comb begin
    mix_in.mix_off     = rf_nxt[tvsg_pkg::REG_MIXER][2*tvsg_pkg::NUM_VOICES-1:0];
    for (int c = 0; c < tvsg_pkg::NUM_VOICES; c++) begin
      mix_in.vol_reg[c] = rf_nxt[tvsg_pkg::REG_VOL_A + c[tvsg_pkg::IDX_W-1:0]][4:0];
    end
    mix_in.tone_level  = tone_level_nxt;
    mix_in.noise_level = noise_level_nxt;
    mix_in.env_volume  = env_volume_nxt;
  end

  tvsg_mix u_mix (
    .mi        (mix_in),
    .amplitude (out_amplitude_nxt)
  );

  assign out_read_data_nxt = is_read ? rf_r[idx_r] : 8'd0;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_data_r <= out_read_data_nxt;
      out_amplitude_r <= out_amplitude_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_amplitude = out_amplitude_r;

endmodule

### rtl/tvsg_tone.sv
// one square-wave tone channel
module tvsg_tone (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick,
  input  logic [tvsg_pkg::TONE_W-1:0] period,
  output logic                        level_nxt
);

  logic [tvsg_pkg::TONE_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                        level_r;

  always_comb begin
    cnt_inc   = cnt_r + 12'd1;
    cnt_nxt   = cnt_r;
    level_nxt = level_r;
    if (tick) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc >= period) begin
        cnt_nxt   = '0;
        level_nxt = ~level_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      level_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

### rtl/tvsg_noise.sv
// noise generator: period counter and 17-bit shift register
module tvsg_noise (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           tick,
  input  logic [tvsg_pkg::NOISE_P_W-1:0] period,
  output logic                           level_nxt
);

  logic [tvsg_pkg::NOISE_C_W-1:0] cnt_r, cnt_nxt, cnt_inc, limit;
  logic [tvsg_pkg::NOISE_S_W-1:0] shift_r, shift_nxt;
  logic                           level_r;
  logic                           fb;

  always_comb begin
    cnt_inc   = cnt_r + 6'd1;
    limit     = {period, 1'b0};
    fb        = shift_r[0] ^ shift_r[3];
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    level_nxt = level_r;
    if (tick) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc >= limit) begin
        cnt_nxt   = '0;
        shift_nxt = {fb, shift_r[tvsg_pkg::NOISE_S_W-1:1]};
        level_nxt = shift_r[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      shift_r <= 17'd1;
      level_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

### rtl/tvsg_env.sv
// envelope unit with attack, alternate, hold and continue rules
module tvsg_env (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tvsg_pkg::env_ctl_t           ctl,
  input  logic [tvsg_pkg::ENV_P_W-1:0] period,
  input  logic [3:0]                   shape,
  output logic [tvsg_pkg::VOL_W-1:0]   volume_nxt
);

  logic [tvsg_pkg::ENV_C_W-1:0] cnt_r, cnt_nxt, cnt_inc, limit;
  logic [tvsg_pkg::ENV_S_W-1:0] step_r, step_nxt;
  logic                         attack_r, attack_nxt, flip;
  logic [tvsg_pkg::VOL_W-1:0]   vol_r;
  logic                         cont, alt, hold;

  always_comb begin
    cont       = shape[tvsg_pkg::SHAPE_CONT];
    alt        = shape[tvsg_pkg::SHAPE_ALT];
    hold       = shape[tvsg_pkg::SHAPE_HOLD];
    cnt_inc    = cnt_r + 21'd1;
    limit      = {period, 5'd0};
    flip       = attack_r ^ alt;
    cnt_nxt    = cnt_r;
    step_nxt   = step_r;
    attack_nxt = attack_r;
    volume_nxt = vol_r;
    if (ctl.restart) begin
      cnt_nxt    = '0;
      step_nxt   = '0;
      attack_nxt = ctl.attack;
      volume_nxt = ctl.attack ? 4'd0 : 4'd15;
    end else if (ctl.tick) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc >= limit) begin
        cnt_nxt = '0;
        // step stays at or below 16, so bit 4 marks the end of a ramp
        if (!step_r[tvsg_pkg::ENV_S_W-1]) begin
          volume_nxt = attack_r ? step_r[3:0] : 4'd15 - step_r[3:0];
          step_nxt   = step_r + 5'd1;
        end else if (!cont) begin
          volume_nxt = 4'd0;
        end else if (hold) begin
          volume_nxt = flip ? 4'd15 : 4'd0;
        end else begin
          attack_nxt = flip;
          step_nxt   = '0;
          volume_nxt = flip ? 4'd0 : 4'd15;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      step_r   <= '0;
      attack_r <= 1'b0;
      vol_r    <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      step_r   <= step_nxt;
      attack_r <= attack_nxt;
      vol_r    <= volume_nxt;
    end
  end

endmodule

### rtl/tvsg_mix.sv
// channel gating, volume table lookup and amplitude sum
module tvsg_mix (
  input  tvsg_pkg::mix_in_t              mi,
  output logic [tvsg_pkg::AMP_W-1:0]     amplitude
);

  logic [tvsg_pkg::NUM_VOICES-1:0][tvsg_pkg::LEVEL_W-1:0] lvl;
  logic [tvsg_pkg::VOL_W-1:0] v;
  logic                       gate;

  always_comb begin
    for (int c = 0; c < tvsg_pkg::NUM_VOICES; c++) begin
      gate = (mi.mix_off[c] | mi.tone_level[c]) &
             (mi.mix_off[c + tvsg_pkg::NUM_VOICES] | mi.noise_level);
      v    = mi.vol_reg[c][tvsg_pkg::VOL_ENV_SEL] ? mi.env_volume : mi.vol_reg[c][3:0];
      lvl[c] = gate ? tvsg_pkg::level_lookup(v) : '0;
    end
    amplitude = {1'b0, lvl[0]} + {1'b0, lvl[1]} + {1'b0, lvl[2]};
  end

endmodule

### rtl/tvsg_checker.sv
// port-level checks for the three voice sound generator
module tvsg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic [6:0] out_amplitude
);

  // three voices at most 42 each
  a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_amplitude <= 7'd126))
    else $error("amplitude above full scale");

  // the input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side free");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_read_data) && $stable(out_amplitude)))
    else $error("stalled result changed");

  // an accepted input transaction finds a valid result behind the input and result registers
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##2 out_valid)
    else $error("accepted transaction produced no result");

endmodule

bind three_voice_sound_generator tvsg_checker u_tvsg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_data (out_read_data),
  .out_amplitude (out_amplitude)
);
